// ===== rtl/itoaf_pkg.sv =====
`default_nettype none

package itoaf_pkg;

   localparam int VALUE_W   = 32;
   localparam int MAX_DIGITS = 10;
   localparam int IDX_W     = 4;

   // print modes
   localparam logic [1:0] MODE_SDEC = 2'd0;
   localparam logic [1:0] MODE_UDEC = 2'd1;
   localparam logic [1:0] MODE_LHEX = 2'd2;
   localparam logic [1:0] MODE_UHEX = 2'd3;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_UA    = 8'h41;

   // ceil(2^35 / 10); floor(v * RECIP10 / 2^35) == v / 10 for every 32-bit v
   localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  mode;
   } req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic [3:0] char_count;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
      logic [3:0]  remainder;
   } div_result_type;

   function automatic logic [7:0] digit_char(input logic [3:0] digit, input logic upper);
      logic [7:0] code;
      if (digit < 4'd10) begin
         code = CHAR_ZERO + {4'd0, digit};
      end else if (upper) begin
         code = CHAR_UA + {4'd0, digit} - 8'd10;
      end else begin
         code = CHAR_LA + {4'd0, digit} - 8'd10;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/itoaf_divu.sv =====
`default_nettype none

// One digit step: divide by 10 (reciprocal multiply) or by 16 (shift).
// Result is valid the cycle after start.
module itoaf_divu (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic                     hex,
   input  wire logic [31:0]              dividend,
   output itoaf_pkg::div_result_type     result
);
   import itoaf_pkg::*;

   logic        busy_ff, busy_in;
   logic        hex_ff;
   logic [31:0] dividend_ff;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] quot;
   logic [31:0] quot_x10;

   assign busy_in = start;
   assign prod_in = 64'(dividend) * 64'(RECIP10);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         hex_ff      <= hex;
         dividend_ff <= dividend;
         prod_ff     <= prod_in;
      end
   end

   always_comb begin
      if (hex_ff) begin
         quot = {4'd0, dividend_ff[31:4]};
      end else begin
         quot = {3'd0, prod_ff[63:RECIP_SHIFT]};
      end
      quot_x10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
   end

   assign result.done      = busy_ff;
   assign result.quotient  = quot;
   assign result.remainder = hex_ff ? dividend_ff[3:0] : (dividend_ff[3:0] - quot_x10[3:0]);

endmodule

`default_nettype wire

// ===== rtl/integer_to_ascii_formatter.sv =====
`default_nettype none

// Flow: each of the d digits (1..10) comes from one step of the shared divide unit,
// then one character per cycle leaves the output register while rsp_stall is low.
// The longest item is a 10-digit negative decimal. Throughput: one item at a
// time; req_stall is high from transfer until the last character is loaded.
// Reset (synchronous) clears the sequencer and the response valid.
module integer_to_ascii_formatter (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire itoaf_pkg::req_type  req_data,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      itoaf_pkg::rsp_type  rsp_data
);
   import itoaf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type      state_ff, state_in;

   // item context
   logic           hex_ff;
   logic           upper_ff;
   logic           sign_pend_ff, sign_pend_in;
   logic [IDX_W-1:0] nd_ff, nd_in;      // digits held in the buffer
   logic [3:0]     pos_ff, pos_in;      // characters already loaded

   // digits, least significant at index 0
   logic [7:0]     digit_buf_ff [MAX_DIGITS];
   logic [IDX_W-1:0] rd_idx;

   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic           req_xfer;
   logic           rsp_xfer;
   logic           load;
   logic           neg;
   logic [31:0]    magnitude;
   logic           div_start;
   logic [31:0]    div_dividend;
   div_result_type div_res;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // magnitude of a negative signed word; 0x80000000 maps to itself
   assign neg       = (req_data.mode == MODE_SDEC) && req_data.value[31];
   assign magnitude = neg ? (~req_data.value + 32'd1) : req_data.value;

   // shared divide unit: started on request transfer and after every digit
   // that leaves a nonzero quotient
   assign div_start    = req_xfer ||
                         ((state_ff == ST_DIV) && div_res.done && (div_res.quotient != 32'd0));
   assign div_dividend = req_xfer ? magnitude : div_res.quotient;

   itoaf_divu u_divu (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .hex      (req_xfer ? req_data.mode[1] : hex_ff),
      .dividend (div_dividend),
      .result   (div_res)
   );

   // next character goes into the output register when it is free or drains
   assign load   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rd_idx = nd_ff - IDX_W'(1);

   always_comb begin
      state_in     = state_ff;
      sign_pend_in = sign_pend_ff;
      nd_in        = nd_ff;
      pos_in       = pos_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               sign_pend_in = neg;
               nd_in        = '0;
               pos_in       = '0;
               state_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               nd_in = nd_ff + IDX_W'(1);
               if (div_res.quotient == 32'd0) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in           = 1'b1;
               pos_in                 = pos_ff + 4'd1;
               rsp_data_in.char_count = pos_ff + 4'd1;
               if (sign_pend_ff) begin
                  rsp_data_in.char_code = CHAR_MINUS;
                  rsp_data_in.last      = 1'b0;
                  sign_pend_in          = 1'b0;
               end else begin
                  rsp_data_in.char_code = digit_buf_ff[rd_idx];
                  rsp_data_in.last      = (nd_ff == IDX_W'(1));
                  nd_in                 = rd_idx;
                  if (nd_ff == IDX_W'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sign_pend_ff <= sign_pend_in;
      nd_ff        <= nd_in;
      pos_ff       <= pos_in;
      rsp_data_ff  <= rsp_data_in;
      if (req_xfer) begin
         hex_ff   <= req_data.mode[1];
         upper_ff <= (req_data.mode == MODE_UHEX);
      end
   end

   // digit store, written as each remainder comes back
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DIV) && div_res.done) begin
         digit_buf_ff[nd_ff] <= digit_char(div_res.remainder, upper_ff);
      end
   end

   // divide results only come back while extracting digits
   assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV))
      else $error("divide result outside digit extraction");

   // emission always has a character left to send
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (nd_ff != '0 || sign_pend_ff))
      else $error("emit state with nothing to send");

   // a response position is always within 1..11
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.char_count != 4'd0 && rsp_data_ff.char_count <= 4'd11))
      else $error("response position out of range");

   // after a non-final character transfers, the next one is ready at once
   assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_data_ff.last) |=> rsp_valid_ff)
      else $error("gap inside a character run");

   // no new request while a run is still being produced
   assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !rsp_data_ff.last) |-> (state_ff == ST_EMIT))
      else $error("run ended early");

endmodule

`default_nettype wire

// ===== sim/integer_to_ascii_formatter_tb.sv =====
`default_nettype none

module integer_to_ascii_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import itoaf_pkg::*;

   localparam int CLK_HALF   = 4;
   localparam int RESET_CYC  = 4;
   localparam int LONG_HOLD  = 200;   // receiver hold-off, in cycles
   localparam int TAIL_CYC   = 40;
   localparam int PHASE_LEN  = 120;
   localparam int NUM_PHASES = 4;

   // One word waiting for the driver: the request itself, the idle cycles to
   // insert ahead of it, and whether it must wait for all output to drain.
   typedef struct {
      req_type     word;
      int unsigned gap;
      bit          wait_drain;
   } pending_word_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pending_word_type pending_words[$];
   rsp_type          expected_chars[$];

   int mismatch_count = 0;
   bit tx_idle        = 1'b1;   // sender inserts random gaps
   bit rx_idle        = 1'b1;   // receiver inserts random stalls
   int hold_requests  = 0;      // bumped by the stimulus to ask for a long hold-off
   int holds_served   = 0;

   // driver state
   bit          gap_armed = 1'b0;
   int unsigned gap_left  = 0;

   // receiver state
   int      stall_left = 0;
   int      hold_left  = 0;
   rsp_type want;

   integer_to_ascii_formatter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Character predictor: turns one accepted word into the run of
   // characters the block should emit, most significant digit first.
   // ------------------------------------------------------------------
   function automatic void format_number(input req_type r);
      logic [31:0] mag;
      logic [31:0] base;
      logic [3:0]  digit;
      logic [7:0]  text[$];
      logic [7:0]  digits[$];
      rsp_type     c;
      mag  = r.value;
      base = (r.mode == MODE_SDEC || r.mode == MODE_UDEC) ? 32'd10 : 32'd16;
      // negative signed word: sign, then magnitude in 32-bit unsigned math,
      // so the most negative word still yields its full 10 digits
      if (r.mode == MODE_SDEC && r.value[31]) begin
         text.push_back(CHAR_MINUS);
         mag = ~r.value + 32'd1;
      end
      // zero still produces a single '0' since the loop body runs once
      do begin
         digit = 4'(mag % base);
         if (digit < 4'd10) begin
            digits.push_front(CHAR_ZERO + 8'(digit));
         end else if (r.mode == MODE_UHEX) begin
            digits.push_front(CHAR_UA + 8'(digit) - 8'd10);
         end else begin
            digits.push_front(CHAR_LA + 8'(digit) - 8'd10);
         end
         mag = mag / base;
      end while (mag != 0);
      foreach (digits[i]) text.push_back(digits[i]);
      foreach (text[k]) begin
         c.char_code  = text[k];
         c.char_count = 4'(k + 1);
         c.last       = (k == text.size() - 1);
         expected_chars.push_back(c);
      end
   endfunction

   // ------------------------------------------------------------------
   // Request driver. Holds valid and data while stalled; otherwise counts
   // down the gap of the next word and then offers it. A word flagged
   // wait_drain is held back until every predicted character has arrived.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_armed = 1'b0;
         gap_left  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            format_number(req_data);
         end
         if (req_valid && req_stall) begin
            // transfer still pending: keep everything as it is
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            if (!gap_armed) begin
               gap_left  = pending_words[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words[0].wait_drain && expected_chars.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               req_data  <= pending_words[0].word;
               req_valid <= 1'b1;
               void'(pending_words.pop_front());
               gap_armed = 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor and stall generator. Each transfer is checked field
   // by field against the oldest prediction; afterwards a fresh stall
   // count is drawn. A long hold-off overrides the random stalls.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected character: code %h count %0d last %b",
                        $time, rsp_data.char_code, rsp_data.char_count, rsp_data.last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.char_code !== want.char_code ||
                   rsp_data.char_count !== want.char_count ||
                   rsp_data.last !== want.last) begin
                  mismatch_count++;
                  $display("%0t: expected code %h count %0d last %b",
                           $time, want.char_code, want.char_count, want.last);
                  $display("%0t:   actual code %h count %0d last %b",
                           $time, rsp_data.char_code, rsp_data.char_count,
                           rsp_data.last);
               end
            end
            stall_left = rx_idle ? $urandom_range(0, 7) : 0;
         end else if (rsp_valid && rsp_stall && stall_left > 0) begin
            stall_left--;
         end
         if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) hold_left--;
         rsp_stall <= (hold_left > 0 || stall_left > 0);
      end
   end

   task automatic add_word(input logic [31:0] value, input logic [1:0] mode,
                           input bit wait_drain = 1'b0);
      pending_word_type p;
      p.word.value = value;
      p.word.mode  = mode;
      p.gap        = tx_idle ? $urandom_range(0, 7) : 0;
      p.wait_drain = wait_drain;
      pending_words.push_back(p);
   endtask

   // Random word biased toward different lengths and digit-count boundaries.
   function automatic logic [31:0] random_word();
      logic [31:0] pw;
      int          k;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom >> $urandom_range(0, 31);
         2: return $urandom_range(0, 20);
         3: return ~32'($urandom_range(0, 1000)) + 32'd1;   // small negative
         4: begin
            pw = 32'd1;
            k  = $urandom_range(0, 9);
            repeat (k) pw = pw * 32'd10;
            return pw + 32'($urandom_range(0, 2)) - 32'd1;
         end
         default: begin
            pw = 32'd1 << (4 * $urandom_range(0, 7));
            return pw + 32'($urandom_range(0, 2)) - 32'd1;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;

      // directed: zero in every mode, extremes, most negative word,
      // digit-count and letter boundaries
      add_word(32'd0, MODE_SDEC);
      add_word(32'd0, MODE_UDEC);
      add_word(32'd0, MODE_LHEX);
      add_word(32'd0, MODE_UHEX);
      add_word(32'hFFFF_FFFF, MODE_SDEC);
      add_word(32'hFFFF_FFFF, MODE_UDEC);
      add_word(32'hFFFF_FFFF, MODE_LHEX);
      add_word(32'hFFFF_FFFF, MODE_UHEX);
      add_word(32'h8000_0000, MODE_SDEC);
      add_word(32'h8000_0000, MODE_UDEC);
      add_word(32'h7FFF_FFFF, MODE_SDEC);
      add_word(32'h8000_0000, MODE_LHEX);
      add_word(32'd1, MODE_SDEC);
      add_word(32'd9, MODE_UDEC);
      add_word(32'd10, MODE_UDEC);
      add_word(32'hFFFF_FFF6, MODE_SDEC);          // -10
      add_word(32'd15, MODE_LHEX);
      add_word(32'd16, MODE_UHEX);
      add_word(32'hABCD_EF01, MODE_LHEX);
      add_word(32'hABCD_EF01, MODE_UHEX);
      add_word(32'd1_000_000_000, MODE_UDEC);
      add_word(32'd999_999_999, MODE_SDEC);
      wait (pending_words.size() == 0);

      // random phases with different idling mixes
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         tx_idle = (ph != 1);
         rx_idle = (ph != 1) && (ph != 2);
         // back-pressure the output long enough for the input to stall
         if (ph == 2) hold_requests++;
         for (int i = 0; i < PHASE_LEN; i++) begin
            // mid-run, the sender pauses until all output has drained
            add_word(random_word(), 2'($urandom_range(0, 3)),
                     (ph == 3 && i == PHASE_LEN / 2));
         end
         wait (pending_words.size() == 0);
      end

      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_chars.size() == 0);
      repeat (TAIL_CYC) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #(4_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
